/* rtl/wtet_pkg.sv */
// Shared types, constants and a helper function for the timed event table.
package wtet_pkg;

  localparam int MAX_EVENTS = 32;
  localparam int ADDR_W     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 32;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 5;
  localparam int NUM_W      = 5;
  localparam int ECNT_W     = 6;
  localparam int WDAY_BITS  = 8;

  localparam logic [7:0] DONT_CARE = 8'd255;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] wmask;
    logic [7:0] dd;
    logic [7:0] mm;
    logic [7:0] yy;
    logic       special;
    logic [7:0] channel;
    logic [7:0] data;
  } entry_t;

  // Declared from the top bit down so that status lands in bit 0.
  typedef struct packed {
    logic [ECNT_W-1:0] entry_count;
    logic [7:0]        data;
    logic [7:0]        channel;
    logic              special;
    logic [NUM_W-1:0]  entry_number;
    logic              matched;
    logic              status;
  } result_t;

  typedef enum logic {
    OSEL_PLAIN,
    OSEL_HELD
  } out_sel_t;

  typedef struct packed {
    logic              capture;
    logic              mem_wr;
    logic              wr_from_rd;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              count_inc;
    logic              count_dec;
    logic              held_load;
    logic              out_load;
    out_sel_t          out_sel;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic              reject;
    logic              index_at_count;
    logic [CNT_W-1:0]  count;
    logic              match;
    logic              out_free;
  } dp_stat_t;

  function automatic logic field_ok(input logic [7:0] stored, input logic [7:0] now);
    return (stored == now) || (stored == DONT_CARE);
  endfunction

endpackage

/* rtl/wtet_ctrl.sv */
// Controller state machine that sequences writes, delete shifts and tick scans.
module wtet_ctrl import wtet_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_DELETE,
    ST_SCAN,
    ST_FINISH,
    ST_RESP
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             cmp_valid, cmp_valid_next;
  logic             held_valid, held_valid_next;
  logic             more;
  logic             hit;
  logic             stall;

  assign s_tready = (state == ST_IDLE);
  assign more     = (ptr < stat.count);
  assign hit      = cmp_valid && stat.match;
  assign stall    = hit && held_valid && !stat.out_free;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    ptr_next        = ptr;
    cmp_valid_next  = cmp_valid;
    held_valid_next = held_valid;
    cmd.capture     = s_tvalid && s_tready;
    cmd.rd_addr     = ADDR_W'(ptr);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmp_valid_next  = 1'b0;
        held_valid_next = 1'b0;
        case (stat.kind)
          KIND_WRITE: state_next = ST_WRITE;
          KIND_DELETE: begin
            ptr_next   = CNT_W'(stat.index) + CNT_W'(1);
            state_next = stat.reject ? ST_RESP : ST_DELETE;
          end
          KIND_TICK: begin
            ptr_next   = '0;
            state_next = ST_SCAN;
          end
          default: state_next = ST_RESP;
        endcase
      end
      ST_WRITE: begin
        cmd.mem_wr    = !stat.reject;
        cmd.count_inc = !stat.reject && stat.index_at_count;
        state_next    = ST_RESP;
      end
      ST_DELETE: begin
        cmd.mem_wr     = cmp_valid;
        cmd.wr_from_rd = 1'b1;
        cmd.rd_en      = more;
        cmp_valid_next = more;
        if (more) begin
          ptr_next = ptr + CNT_W'(1);
        end else if (!cmp_valid) begin
          cmd.count_dec = 1'b1;
          state_next    = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.held_load = hit;
          if (hit && held_valid) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_HELD;
          end
          held_valid_next = held_valid || hit;
          cmd.rd_en       = more;
          cmp_valid_next  = more;
          if (more) begin
            ptr_next = ptr + CNT_W'(1);
          end else if (!cmp_valid) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel     = held_valid ? OSEL_HELD : OSEL_PLAIN;
          cmd.out_last    = 1'b1;
          held_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_PLAIN;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ptr        <= '0;
      cmp_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      cmp_valid  <= cmp_valid_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

/* rtl/wtet_dpath.sv */
// Datapath: item registers, entry memory, match logic, entry count and output register.
module wtet_dpath import wtet_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  entry_t            mem [MAX_EVENTS];
  entry_t            item;
  entry_t            in_entry;
  entry_t            rd_entry;
  entry_t            wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  index;
  logic [IDX_W-1:0]  in_index;
  logic              reject, reject_next;
  logic [CNT_W-1:0]  count;
  logic              full_date;
  logic [NUM_W-1:0]  held_num;
  entry_t            held;
  result_t           out_res;
  result_t           res_plain;
  result_t           res_held;
  logic              wk;
  logic              time_ok;
  logic              date_ok;

  // Input tdata from bit 0: index, second, minute, hour, weekday, day, month,
  // year, action_special, action_channel, action_data.
  assign in_index         = s_tdata[4:0];
  assign in_entry.sec     = s_tdata[12:5];
  assign in_entry.min     = s_tdata[20:13];
  assign in_entry.hr      = s_tdata[28:21];
  assign in_entry.wmask   = s_tdata[36:29];
  assign in_entry.dd      = s_tdata[44:37];
  assign in_entry.mm      = s_tdata[52:45];
  assign in_entry.yy      = s_tdata[60:53];
  assign in_entry.special = s_tdata[61];
  assign in_entry.channel = s_tdata[69:62];
  assign in_entry.data    = s_tdata[77:70];

  always_comb begin
    case (s_tuser)
      KIND_WRITE:  reject_next = !((32'(in_index) <= 32'(count)) &&
                                   (32'(in_index) < 32'(MAX_EVENTS)));
      KIND_DELETE: reject_next = !(32'(in_index) < 32'(count));
      default:     reject_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind   <= s_tuser;
      index  <= in_index;
      item   <= in_entry;
      reject <= reject_next;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_date <= 1'b1;
      count     <= '0;
    end else begin
      if (cfg_valid) begin
        full_date <= cfg_data;
      end
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign wr_data = cmd.wr_from_rd ? rd_entry : item;
  assign wr_addr = cmd.wr_from_rd ? (rd_addr - ADDR_W'(1)) : ADDR_W'(index);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_entry <= mem[cmd.rd_addr];
      rd_addr  <= cmd.rd_addr;
    end
  end

  // On a tick the item's weekday field holds the current weekday, 1 to 8.
  assign wk = (item.wmask != 8'd0) && (item.wmask <= 8'(WDAY_BITS)) &&
              rd_entry.wmask[3'(item.wmask - 8'd1)];
  assign time_ok = field_ok(rd_entry.sec, item.sec) && field_ok(rd_entry.min, item.min) &&
                   field_ok(rd_entry.hr, item.hr) && wk;
  assign date_ok = field_ok(rd_entry.dd, item.dd) && field_ok(rd_entry.mm, item.mm) &&
                   field_ok(rd_entry.yy, item.yy);

  always_ff @(posedge clk) begin
    if (cmd.held_load) begin
      held     <= rd_entry;
      held_num <= NUM_W'(rd_addr);
    end
  end

  always_comb begin
    res_plain              = '0;
    res_plain.status       = reject;
    res_plain.entry_number = ((kind == KIND_WRITE) || (kind == KIND_DELETE)) ? index : '0;
    res_plain.entry_count  = ECNT_W'(count);
    res_held               = '0;
    res_held.matched       = 1'b1;
    res_held.entry_number  = held_num;
    res_held.special       = held.special;
    res_held.channel       = held.channel;
    res_held.data          = held.data;
    res_held.entry_count   = ECNT_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res <= (cmd.out_sel == OSEL_HELD) ? res_held : res_plain;
      m_tlast <= cmd.out_last;
    end
  end

  assign m_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_res};

  assign stat.kind           = kind;
  assign stat.index          = index;
  assign stat.reject         = reject;
  assign stat.index_at_count = (32'(index) == 32'(count));
  assign stat.count          = count;
  assign stat.match          = time_ok && (date_ok || !full_date);
  assign stat.out_free       = !m_tvalid || m_tready;

endmodule

/* rtl/wildcard_time_event_table_top.sv */
// Top level of the timed event table: controller plus datapath.
// A write shows its single result after the dispatch, write and response states, an unused
// kind after dispatch and response. A delete shifts each entry above the index down one place;
// a rejected delete goes straight to its result. A tick scans every entry before its final
// result; one entry is read per cycle, and a stalled output holds the scan when a match waits.
// The next item is taken from the cycle after the final result is loaded; reset clears the
// entry count and the output valid and sets full date matching.
module wildcard_time_event_table_top import wtet_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // index, second, minute, hour, weekday, day, month, year, action_special,
  // action_channel, action_data
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,     // kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status, matched, entry_number, out_special, out_channel, out_data, entry_count
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data     // full_date_match
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wtet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  wtet_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* rtl/wtet_checker.sv */
// Port-level checker for the timed event table and its bind to the top level.
module wtet_checker import wtet_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic                 m_tlast
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_fin;

  assign in_acc  = s_tvalid && s_tready;
  assign out_fin = m_tvalid && m_tready && m_tlast;

  // Counts accepted items whose final result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_acc && !out_fin) begin
      pending <= pending + 2'd1;
    end else if (!in_acc && out_fin) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (pending != 2'd2))
    else $error("new item accepted before the previous one finished");

  a_out_owned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != 2'd0))
    else $error("output item without an accepted input item");

  a_only_matches_repeat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[1] && !m_tdata[0])
    else $error("non-final item is not a match");

  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tlast && !m_tdata[1])
    else $error("rejected item is not a single unmatched result");

endmodule

bind wildcard_time_event_table_top wtet_checker u_wtet_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast)
);

/* sim/wildcard_time_event_table_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the timed event table: directed and random items against a predictor.
module wildcard_time_event_table_top_tb import wtet_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Input item fields, declared from the top bit down so that index lands in bit 0.
  typedef struct packed {
    logic [7:0]       data;
    logic [7:0]       channel;
    logic             special;
    logic [7:0]       year;
    logic [7:0]       month;
    logic [7:0]       day;
    logic [7:0]       weekday;
    logic [7:0]       hour;
    logic [7:0]       minute;
    logic [7:0]       second;
    logic [IDX_W-1:0] index;
  } slot_fields_t;

  typedef struct packed {
    logic    last;
    result_t res;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;

  slot_fields_t timer_slots [MAX_EVENTS];
  int unsigned  slot_count = 0;
  logic         date_match_on = 1'b1;
  outcome_t     awaited_results [$];
  int           mismatches = 0;
  int unsigned  cycles = 0;
  logic         gaps_on = 1'b1;

  wildcard_time_event_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    result_t  got;
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (awaited_results.size() == 0) begin
        report_mismatch("result item arrived with none awaited");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", got.status, want.res.status);
        check_field("matched", got.matched, want.res.matched);
        check_field("entry_number", got.entry_number, want.res.entry_number);
        check_field("out_special", got.special, want.res.special);
        check_field("out_channel", got.channel, want.res.channel);
        check_field("out_data", got.data, want.res.data);
        check_field("entry_count", got.entry_count, want.res.entry_count);
        check_field("last", m_tlast, want.last);
      end
    end
    m_tready <= (gaps_on && $urandom_range(99) < 14) ? 1'b0 : 1'b1;
  end

  function automatic logic wild_eq(input logic [7:0] stored, input logic [7:0] now);
    return (stored == now) || (stored == DONT_CARE);
  endfunction

  function automatic logic slot_fires(input slot_fields_t s, input slot_fields_t now);
    logic day_ok;
    day_ok = (now.weekday >= 8'd1 && now.weekday <= 8'd8) ?
             s.weekday[now.weekday - 8'd1] : 1'b0;
    if (!(wild_eq(s.second, now.second) && wild_eq(s.minute, now.minute) &&
          wild_eq(s.hour, now.hour) && day_ok)) begin
      return 1'b0;
    end
    if (date_match_on) begin
      return wild_eq(s.day, now.day) && wild_eq(s.month, now.month) &&
             wild_eq(s.year, now.year);
    end
    return 1'b1;
  endfunction

  // Updates the table copy for one accepted item and queues the result items it causes.
  task automatic predict_outcome(input logic [KIND_W-1:0] kind, input slot_fields_t f);
    outcome_t o;
    outcome_t held;
    logic     have;
    o = '0;
    held = '0;
    have = 1'b0;
    case (kind)
      KIND_WRITE: begin
        o.res.status = 1'b1;
        if (f.index <= slot_count && f.index < MAX_EVENTS) begin
          timer_slots[f.index] = f;
          if (f.index == slot_count) slot_count++;
          o.res.status = 1'b0;
        end
        o.res.entry_number = f.index;
      end
      KIND_DELETE: begin
        o.res.status = 1'b1;
        if (f.index < slot_count) begin
          for (int i = f.index; i + 1 < slot_count; i++) timer_slots[i] = timer_slots[i + 1];
          slot_count--;
          o.res.status = 1'b0;
        end
        o.res.entry_number = f.index;
      end
      KIND_TICK: begin
        for (int i = 0; i < slot_count; i++) begin
          if (slot_fires(timer_slots[i], f)) begin
            if (have) awaited_results.push_back(held);
            held = '0;
            held.res.matched = 1'b1;
            held.res.entry_number = NUM_W'(i);
            held.res.special = timer_slots[i].special;
            held.res.channel = timer_slots[i].channel;
            held.res.data = timer_slots[i].data;
            held.res.entry_count = ECNT_W'(slot_count);
            have = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (have) o = held;
    else o.res.entry_count = ECNT_W'(slot_count);
    o.last = 1'b1;
    awaited_results.push_back(o);
  endtask

  task automatic send_item(input logic [KIND_W-1:0] kind, input slot_fields_t f);
    if (gaps_on && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= S_TDATA_W'(f);
    do @(posedge clk); while (!s_tready);
    predict_outcome(kind, f);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_date_match(input logic on);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data <= on;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    date_match_on = on;
  endtask

  function automatic slot_fields_t slot_of(input logic [IDX_W-1:0] idx,
                                           input logic [7:0] s, input logic [7:0] mi,
                                           input logic [7:0] h, input logic [7:0] wd,
                                           input logic [7:0] d, input logic [7:0] mo,
                                           input logic [7:0] y, input logic sp,
                                           input logic [7:0] ch, input logic [7:0] dt);
    slot_fields_t f;
    f.index = idx;
    f.second = s;
    f.minute = mi;
    f.hour = h;
    f.weekday = wd;
    f.day = d;
    f.month = mo;
    f.year = y;
    f.special = sp;
    f.channel = ch;
    f.data = dt;
    return f;
  endfunction

  // Values cluster on 0, 1 and the don't-care value so that entries and ticks meet often.
  function automatic logic [7:0] near_value();
    int r;
    r = $urandom_range(99);
    if (r < 35) return DONT_CARE;
    if (r < 85) return 8'($urandom_range(1));
    return 8'($urandom_range(255));
  endfunction

  function automatic slot_fields_t random_slot(input logic [IDX_W-1:0] idx);
    return slot_of(idx, near_value(), near_value(), near_value(),
                   ($urandom_range(99) < 20) ? 8'hFF : 8'($urandom_range(255)),
                   near_value(), near_value(), near_value(), 1'($urandom_range(1)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
  endfunction

  function automatic slot_fields_t random_tick();
    slot_fields_t f;
    int           r;
    f = random_slot(IDX_W'($urandom_range(31)));
    r = $urandom_range(99);
    if (r < 80) f.weekday = 8'($urandom_range(1, 7));
    else if (r < 86) f.weekday = 8'd8;
    else if (r < 92) f.weekday = 8'd0;
    else f.weekday = 8'($urandom_range(255));
    return f;
  endfunction

  task automatic test_empty_table();
    send_item(KIND_TICK, random_tick());
    send_item(KIND_WRITE, random_slot(5'd1));
    send_item(KIND_WRITE, random_slot(5'd31));
    send_item(KIND_DELETE, random_slot(5'd0));
    send_item(KIND_DELETE, random_slot(5'd31));
    send_item(KIND_UNUSED, slot_of(5'd31, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   1'b1, 8'hFF, 8'hFF));
  endtask

  task automatic test_entry_extremes();
    send_item(KIND_WRITE, slot_of(5'd0, 8'd255, 8'd255, 8'd255, 8'hFF, 8'd255, 8'd255,
                                  8'd255, 1'b1, 8'hFF, 8'hFF));
    send_item(KIND_WRITE, slot_of(5'd1, 8'd0, 8'd0, 8'd0, 8'h01, 8'd0, 8'd0, 8'd0,
                                  1'b0, 8'h00, 8'h00));
    send_item(KIND_WRITE, slot_of(5'd2, 8'd59, 8'd30, 8'd23, 8'h80, 8'd31, 8'd12, 8'd99,
                                  1'b1, 8'h5A, 8'hA5));
    send_item(KIND_TICK, slot_of(5'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0,
                                 1'b0, 8'h00, 8'h00));
    send_item(KIND_TICK, slot_of(5'd31, 8'd59, 8'd30, 8'd23, 8'd8, 8'd31, 8'd12, 8'd99,
                                 1'b1, 8'hFF, 8'hFF));
    send_item(KIND_TICK, slot_of(5'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                 1'b0, 8'h00, 8'h00));
    send_item(KIND_TICK, slot_of(5'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                 8'd255, 1'b0, 8'h00, 8'h00));
    send_item(KIND_WRITE, slot_of(5'd1, 8'd255, 8'd0, 8'd255, 8'h7F, 8'd0, 8'd255, 8'd0,
                                  1'b1, 8'h0F, 8'hF0));
    send_item(KIND_TICK, slot_of(5'd0, 8'd7, 8'd0, 8'd13, 8'd7, 8'd0, 8'd9, 8'd0,
                                 1'b0, 8'h00, 8'h00));
  endtask

  task automatic test_date_match();
    slot_fields_t now;
    now = slot_of(5'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd5, 8'd6, 8'd7, 1'b0, 8'h00, 8'h00);
    write_date_match(1'b0);
    send_item(KIND_TICK, now);
    write_date_match(1'b1);
    send_item(KIND_TICK, now);
  endtask

  task automatic test_delete_shift();
    send_item(KIND_DELETE, random_slot(5'd1));
    send_item(KIND_TICK, slot_of(5'd3, 8'd59, 8'd30, 8'd23, 8'd8, 8'd31, 8'd12, 8'd99,
                                 1'b0, 8'h00, 8'h00));
    send_item(KIND_DELETE, random_slot(5'd1));
    send_item(KIND_DELETE, random_slot(5'd1));
    send_item(KIND_TICK, random_tick());
  endtask

  task automatic test_full_table();
    slot_fields_t f;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      f = random_slot(IDX_W'(i));
      f.second = DONT_CARE;
      f.minute = DONT_CARE;
      f.hour = DONT_CARE;
      f.weekday = 8'hFF;
      f.day = DONT_CARE;
      f.month = DONT_CARE;
      f.year = DONT_CARE;
      send_item(KIND_WRITE, f);
    end
    f = random_tick();
    f.weekday = 8'($urandom_range(1, 8));
    send_item(KIND_TICK, f);
    send_item(KIND_WRITE, random_slot(5'd31));
    send_item(KIND_DELETE, random_slot(5'd0));
    send_item(KIND_TICK, f);
  endtask

  task automatic test_random_traffic(input int items, input int write_pct);
    logic [KIND_W-1:0] kind;
    slot_fields_t      f;
    int                r;
    int                idx;
    repeat (items) begin
      r = $urandom_range(99);
      if (r < write_pct) begin
        kind = KIND_WRITE;
        if (slot_count < MAX_EVENTS && $urandom_range(99) < 65) idx = slot_count;
        else if (slot_count > 0 && $urandom_range(99) < 85) idx = $urandom_range(slot_count - 1);
        else idx = $urandom_range(31);
        f = random_slot(IDX_W'(idx));
      end else if (r < write_pct + 15) begin
        kind = KIND_DELETE;
        if (slot_count > 0 && $urandom_range(99) < 85) idx = $urandom_range(slot_count - 1);
        else idx = $urandom_range(31);
        f = random_slot(IDX_W'(idx));
      end else if (r < 96) begin
        kind = KIND_TICK;
        f = random_tick();
      end else begin
        kind = KIND_UNUSED;
        f = random_slot(IDX_W'($urandom_range(31)));
      end
      send_item(kind, f);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_entry_extremes();
    test_date_match();
    test_delete_shift();
    test_full_table();
    write_date_match(1'b0);
    test_random_traffic(45, 45);
    gaps_on = 1'b0;
    test_random_traffic(30, 40);
    gaps_on = 1'b1;
    write_date_match(1'b1);
    test_random_traffic(45, 35);
    wait_all_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
